@@ design/hpd_pkg.sv @@
// hpd_pkg: shared constants, register codes and helpers for the hex prism
// distance evaluator. Used by hpd_hyp, hpd_div and hex_prism_distance_eval.
package hpd_pkg;

  // default fraction width of the Q format
  localparam int FRAC_BITS_DEF = 16;

  // Q0.30 geometry constants
  localparam int          K_SHIFT    = 30;
  localparam logic [29:0] K_SQRT_3_4 = 30'd929887697;
  localparam logic [29:0] K_SQRT_1_3 = 30'd619925131;
  localparam logic [29:0] K_HALF     = 30'd536870912;

  // configuration port shape
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 31;

  typedef enum logic [CFG_AW-1:0] {
    REG_HEX_RADIUS      = 3'd0,
    REG_HALF_HEIGHT     = 3'd1,
    REG_SWAP_XY         = 3'd2,
    REG_SWAP_XZ         = 3'd3,
    REG_SHELL_ENABLE    = 3'd4,
    REG_SHELL_THICKNESS = 3'd5
  } cfg_reg_t;

  // magnitude of a 32-bit two's complement value, exact for the most negative
  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

endpackage

@@ design/hpd_hyp.sv @@
// hpd_hyp: pipelined floor(sqrt(a*a + b*b)) with a sideband that travels along.
// Split squares, one sum stage, then two root bits per stage. Uses hpd_pkg.
module hpd_hyp
  import hpd_pkg::*;
#(
  parameter int IW = 33,
  parameter int SW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [IW-1:0] a,
  input  logic [IW-1:0] b,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [IW:0]   root,
  output logic [SW-1:0] out_side
);

  localparam int H  = (IW + 1) / 2;
  localparam int RW = IW + 1;
  localparam int NW = 2 * RW + 1;
  localparam int NS = (RW + 1) / 2;

  function automatic logic [2*H-1:0] mul_u(input logic [H-1:0] x, input logic [H-1:0] y);
    return {{H{1'b0}}, x} * {{H{1'b0}}, y};
  endfunction

  logic [H-1:0] a_hi, a_lo, b_hi, b_lo;

  assign a_hi = H'(a >> H);
  assign a_lo = a[H-1:0];
  assign b_hi = H'(b >> H);
  assign b_lo = b[H-1:0];

  // partial products of both squares
  logic           va;
  logic [SW-1:0]  side_a;
  logic [2*H-1:0] pa_hh, pa_hl, pa_ll, pb_hh, pb_hl, pb_ll;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (en) begin
      va <= in_valid;
    end
    if (en) begin
      side_a <= in_side;
      pa_hh  <= mul_u(a_hi, a_hi);
      pa_hl  <= mul_u(a_hi, a_lo);
      pa_ll  <= mul_u(a_lo, a_lo);
      pb_hh  <= mul_u(b_hi, b_hi);
      pb_hl  <= mul_u(b_hi, b_lo);
      pb_ll  <= mul_u(b_lo, b_lo);
    end
  end

  logic          valid_q [0:NS];
  logic [NW-1:0] rem_q   [0:NS];
  logic [RW-1:0] res_q   [0:NS];
  logic [SW-1:0] side_q  [0:NS];

  logic [NW-1:0] sum_n;

  // full sum of squares
  always_comb begin
    sum_n = (NW'(pa_hh) << (2 * H)) + (NW'(pa_hl) << (H + 1)) + NW'(pa_ll)
          + (NW'(pb_hh) << (2 * H)) + (NW'(pb_hl) << (H + 1)) + NW'(pb_ll);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q[0] <= 1'b0;
    end else if (en) begin
      valid_q[0] <= va;
    end
    if (en) begin
      rem_q[0]  <= sum_n;
      res_q[0]  <= '0;
      side_q[0] <= side_a;
    end
  end

  // restoring root, two bits per stage
  for (genvar s = 0; s < NS; s++) begin : g_root
    logic [NW-1:0] rem_n;
    logic [RW-1:0] res_n;

    always_comb begin
      logic [NW-1:0] r;
      logic [NW-1:0] trial;
      logic [RW-1:0] q;
      int            bpos;
      r = rem_q[s];
      q = res_q[s];
      trial = '0;
      for (int k = 0; k < 2; k++) begin
        bpos = RW - 1 - (2 * s + k);
        if (bpos >= 0) begin
          trial = (NW'(q) << (bpos + 1)) + (NW'(1) << (2 * bpos));
          if (trial <= r) begin
            r = r - trial;
            q = q | (RW'(1) << bpos);
          end
        end
      end
      rem_n = r;
      res_n = q;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid_q[s+1] <= 1'b0;
      end else if (en) begin
        valid_q[s+1] <= valid_q[s];
      end
      if (en) begin
        rem_q[s+1]  <= rem_n;
        res_q[s+1]  <= res_n;
        side_q[s+1] <= side_q[s];
      end
    end
  end

  assign out_valid = valid_q[NS];
  assign root      = res_q[NS];
  assign out_side  = side_q[NS];

endmodule

@@ design/hpd_div.sv @@
// hpd_div: pipelined (|de0| << FB) / (scale + 2^FB), sign restore and running min.
// Two quotient bits per stage, result held in the output register. Uses hpd_pkg.
module hpd_div
  import hpd_pkg::*;
#(
  parameter int FB = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [31:0] de0_in,
  input  logic [31:0] prev_in,
  input  logic [30:0] scale_in,
  output logic        out_valid,
  output logic [31:0] de0_out,
  output logic [31:0] new_dist_out
);

  localparam int NS = 16;

  logic        valid_q [0:NS];
  logic [31:0] rem_q   [0:NS];
  logic [31:0] low_q   [0:NS];
  logic [31:0] quo_q   [0:NS];
  logic [31:0] den_q   [0:NS];
  logic [31:0] de0_q   [0:NS];
  logic [31:0] prev_q  [0:NS];

  logic [31:0] mag_in;

  assign mag_in = mag32(de0_in);

  // entry: upper dividend bits stay below the divisor
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q[0] <= 1'b0;
    end else if (en) begin
      valid_q[0] <= in_valid;
    end
    if (en) begin
      rem_q[0]  <= mag_in >> (32 - FB);
      low_q[0]  <= mag_in << FB;
      quo_q[0]  <= '0;
      den_q[0]  <= 32'(scale_in) + (32'd1 << FB);
      de0_q[0]  <= de0_in;
      prev_q[0] <= prev_in;
    end
  end

  for (genvar s = 0; s < NS; s++) begin : g_div
    logic [31:0] rem_n, low_n, quo_n;

    always_comb begin
      logic [32:0] sh;
      logic [31:0] r;
      logic [31:0] lo;
      logic [31:0] q;
      r  = rem_q[s];
      lo = low_q[s];
      q  = quo_q[s];
      sh = '0;
      for (int k = 0; k < 2; k++) begin
        sh = {r, lo[31]};
        lo = lo << 1;
        if (sh >= {1'b0, den_q[s]}) begin
          sh = sh - {1'b0, den_q[s]};
          q  = {q[30:0], 1'b1};
        end else begin
          q  = {q[30:0], 1'b0};
        end
        r = sh[31:0];
      end
      rem_n = r;
      low_n = lo;
      quo_n = q;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid_q[s+1] <= 1'b0;
      end else if (en) begin
        valid_q[s+1] <= valid_q[s];
      end
      if (en) begin
        rem_q[s+1]  <= rem_n;
        low_q[s+1]  <= low_n;
        quo_q[s+1]  <= quo_n;
        den_q[s+1]  <= den_q[s];
        de0_q[s+1]  <= de0_q[s];
        prev_q[s+1] <= prev_q[s];
      end
    end
  end

  // sign restore and running minimum
  logic signed [33:0] quo_s;
  logic signed [33:0] prev_s;
  logic [31:0]        min_n;

  always_comb begin
    quo_s  = de0_q[NS][31] ? -$signed({2'b00, quo_q[NS]}) : $signed({2'b00, quo_q[NS]});
    prev_s = 34'($signed(prev_q[NS]));
    min_n  = (prev_s < quo_s) ? prev_q[NS] : quo_s[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= valid_q[NS];
    end
    if (en) begin
      de0_out      <= de0_q[NS];
      new_dist_out <= min_n;
    end
  end

endmodule

@@ design/hex_prism_distance_eval.sv @@
// hex_prism_distance_eval: hexagonal prism signed distance, one point per cycle unless stalled.
// Top level; uses hpd_pkg, hpd_hyp (two root units) and hpd_div.
//
//   channel  | handshake            | payload
//   ---------+----------------------+----------------------------------------
//   in       | in_valid / in_stall  | pos_x pos_y pos_z prev_dist de_scale
//   out      | out_valid / out_stall| de0 new_dist
//   config   | cfg_wen              | cfg_addr cfg_wdata
//
// one item per cycle while the pipeline is not held; there are 6 front stages, a
// side root unit of 2 + ceil((IW+1)/2) = 19 stages, one corner stage, an outer
// root unit of 20, one saturation stage and 18 divider stages.
// rst is synchronous; it clears the valid bits and resets the configuration registers.
// the whole pipeline holds while a result waits under out_stall.
module hex_prism_distance_eval
  import hpd_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [31:0]       pos_x,
  input  logic [31:0]       pos_y,
  input  logic [31:0]       pos_z,
  input  logic [31:0]       prev_dist,
  input  logic [30:0]       de_scale,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [31:0]       de0,
  output logic [31:0]       new_dist,
  input  logic              cfg_wen,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  localparam int IW1 = 33;
  localparam int IW2 = 34;
  localparam int SW1 = 2 + 33 + 32 + 31;
  localparam int SW2 = 36 + 32 + 31;

  // configuration registers
  logic [30:0] hex_radius, half_height, shell_thickness;
  logic        swap_xy, swap_xz, shell_enable;
  logic [30:0] clamp_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      hex_radius      <= 31'(1) << FRAC_BITS;
      half_height     <= 31'(1) << FRAC_BITS;
      swap_xy         <= 1'b0;
      swap_xz         <= 1'b0;
      shell_enable    <= 1'b0;
      shell_thickness <= '0;
    end else if (cfg_wen) begin
      case (cfg_reg_t'(cfg_addr))
        REG_HEX_RADIUS:      hex_radius      <= cfg_wdata;
        REG_HALF_HEIGHT:     half_height     <= cfg_wdata;
        REG_SWAP_XY:         swap_xy         <= cfg_wdata[0];
        REG_SWAP_XZ:         swap_xz         <= cfg_wdata[0];
        REG_SHELL_ENABLE:    shell_enable    <= cfg_wdata[0];
        REG_SHELL_THICKNESS: shell_thickness <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // side clamp bound, round(hex_radius / sqrt(3))
  logic [61:0] clamp_p;
  assign clamp_p = {31'd0, hex_radius} * {32'd0, K_SQRT_1_3} + (62'd1 << (K_SHIFT - 1));

  always_ff @(posedge clk) begin
    clamp_c <= clamp_p[K_SHIFT +: 31];
  end

  // global advance
  logic en;
  logic div_valid;

  assign en        = !(div_valid && out_stall);
  assign in_stall  = !en;
  assign out_valid = div_valid;

  // stage 1: fold by absolute value and swaps
  logic        s1_v;
  logic [31:0] s1_x, s1_y, s1_z, s1_prev;
  logic [30:0] s1_scale;
  logic [31:0] fx, fy, fz, fx1, fy1;

  always_comb begin
    fx  = mag32(pos_x);
    fy  = mag32(pos_y);
    fz  = mag32(pos_z);
    fx1 = swap_xy ? fy : fx;
    fy1 = swap_xy ? fx : fy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (en) begin
      s1_v <= in_valid;
    end
    if (en) begin
      s1_x     <= swap_xz ? fz : fx1;
      s1_y     <= fy1;
      s1_z     <= swap_xz ? fx1 : fz;
      s1_prev  <= prev_dist;
      s1_scale <= de_scale;
    end
  end

  // stage 2: edge normal products
  logic        s2_v;
  logic [61:0] s2_ph, s2_pk;
  logic [31:0] s2_x, s2_y, s2_z, s2_prev;
  logic [30:0] s2_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (en) begin
      s2_v <= s1_v;
    end
    if (en) begin
      s2_ph    <= {30'd0, s1_y} * {32'd0, K_HALF};
      s2_pk    <= {30'd0, s1_x} * {32'd0, K_SQRT_3_4};
      s2_x     <= s1_x;
      s2_y     <= s1_y;
      s2_z     <= s1_z;
      s2_prev  <= s1_prev;
      s2_scale <= s1_scale;
    end
  end

  // stage 3: rounded edge offset, zero when the point is inside
  logic               s3_v;
  logic signed [32:0] s3_m;
  logic [31:0]        s3_x, s3_y, s3_z, s3_prev;
  logic [30:0]        s3_scale;
  logic signed [62:0] t_w, t_r;
  logic signed [32:0] m_n;

  always_comb begin
    t_w = $signed({1'b0, s2_ph}) - $signed({1'b0, s2_pk});
    t_r = (t_w + (63'sd1 <<< (K_SHIFT - 1))) >>> K_SHIFT;
    m_n = t_w[62] ? t_r[32:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (en) begin
      s3_v <= s2_v;
    end
    if (en) begin
      s3_m     <= m_n;
      s3_x     <= s2_x;
      s3_y     <= s2_y;
      s3_z     <= s2_z;
      s3_prev  <= s2_prev;
      s3_scale <= s2_scale;
    end
  end

  // stage 4: fold product and new y
  logic               s4_v;
  logic signed [64:0] s4_p2;
  logic signed [33:0] s4_py;
  logic [31:0]        s4_x, s4_z, s4_prev;
  logic [30:0]        s4_scale;
  logic signed [63:0] fold_p;

  assign fold_p = s3_m * $signed({1'b0, K_SQRT_3_4});

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_v <= 1'b0;
    end else if (en) begin
      s4_v <= s3_v;
    end
    if (en) begin
      s4_p2    <= {fold_p, 1'b0};
      s4_py    <= $signed({2'b00, s3_y}) - 34'(s3_m);
      s4_x     <= s3_x;
      s4_z     <= s3_z;
      s4_prev  <= s3_prev;
      s4_scale <= s3_scale;
    end
  end

  // stage 5: folded x, side and height offsets
  logic               s5_v;
  logic signed [34:0] s5_px, s5_sy;
  logic signed [32:0] s5_hz;
  logic [31:0]        s5_prev;
  logic [30:0]        s5_scale;
  logic signed [64:0] adj_w;

  assign adj_w = (s4_p2 + (65'sd1 <<< (K_SHIFT - 1))) >>> K_SHIFT;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_v <= 1'b0;
    end else if (en) begin
      s5_v <= s4_v;
    end
    if (en) begin
      s5_px    <= $signed({3'b000, s4_x}) + adj_w[34:0];
      s5_sy    <= 35'(s4_py) - $signed({4'b0000, hex_radius});
      s5_hz    <= $signed({1'b0, s4_z}) - $signed({2'b00, half_height});
      s5_prev  <= s4_prev;
      s5_scale <= s4_scale;
    end
  end

  // stage 6: clamp along the edge, magnitudes for the first root
  logic                s6_v;
  logic [IW1-1:0]      s6_dx, s6_dy;
  logic [SW1-1:0]      s6_side;
  logic signed [34:0]  c_pos, c_neg, cx, dxs;

  always_comb begin
    c_pos = $signed({4'b0000, clamp_c});
    c_neg = -c_pos;
    if (s5_px < c_neg) begin
      cx = c_neg;
    end else if (s5_px > c_pos) begin
      cx = c_pos;
    end else begin
      cx = s5_px;
    end
    dxs = s5_px - cx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_v <= 1'b0;
    end else if (en) begin
      s6_v <= s5_v;
    end
    if (en) begin
      s6_dx   <= dxs[34] ? IW1'(-dxs) : IW1'(dxs);
      s6_dy   <= s5_sy[34] ? IW1'(-s5_sy) : IW1'(s5_sy);
      s6_side <= {(s5_sy > 35'sd0), s5_sy[34], s5_hz, s5_prev, s5_scale};
    end
  end

  logic           h1_v;
  logic [IW1:0]   h1_root;
  logic [SW1-1:0] h1_side;

  hpd_hyp #(.IW(IW1), .SW(SW1)) u_hyp_side (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s6_v),
    .a         (s6_dx),
    .b         (s6_dy),
    .in_side   (s6_side),
    .out_valid (h1_v),
    .root      (h1_root),
    .out_side  (h1_side)
  );

  // stage 7: signed side distance, shell, prism corner terms
  logic               h1_pos, h1_neg;
  logic signed [32:0] h1_hz;
  logic [31:0]        h1_prev;
  logic [30:0]        h1_scale;
  logic signed [35:0] sd0, sd1, hz36, hi36, lo_n;

  assign {h1_pos, h1_neg, h1_hz, h1_prev, h1_scale} = h1_side;

  always_comb begin
    if (h1_pos) begin
      sd0 = $signed({2'b00, h1_root});
    end else if (h1_neg) begin
      sd0 = -$signed({2'b00, h1_root});
    end else begin
      sd0 = '0;
    end
    sd1  = shell_enable ? (sd0[35] ? -sd0 : sd0) - $signed({5'b00000, shell_thickness})
                        : sd0;
    hz36 = 36'(h1_hz);
    hi36 = (sd1 > hz36) ? sd1 : hz36;
    lo_n = hi36[35] ? hi36 : '0;
  end

  logic           s7_v;
  logic [IW2-1:0] s7_mx, s7_my;
  logic [SW2-1:0] s7_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_v <= 1'b0;
    end else if (en) begin
      s7_v <= h1_v;
    end
    if (en) begin
      s7_mx   <= (sd1 > 36'sd0) ? IW2'(sd1) : '0;
      s7_my   <= (h1_hz > 33'sd0) ? IW2'(h1_hz) : '0;
      s7_side <= {lo_n, h1_prev, h1_scale};
    end
  end

  logic           h2_v;
  logic [IW2:0]   h2_root;
  logic [SW2-1:0] h2_side;

  hpd_hyp #(.IW(IW2), .SW(SW2)) u_hyp_out (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s7_v),
    .a         (s7_mx),
    .b         (s7_my),
    .in_side   (s7_side),
    .out_valid (h2_v),
    .root      (h2_root),
    .out_side  (h2_side)
  );

  // stage 8: total distance, saturated to 32 bits
  logic signed [35:0] h2_lo;
  logic [31:0]        h2_prev;
  logic [30:0]        h2_scale;
  logic signed [36:0] total;
  logic [31:0]        de0_n;

  assign {h2_lo, h2_prev, h2_scale} = h2_side;

  always_comb begin
    total = 37'(h2_lo) + $signed({2'b00, h2_root});
    if (total > 37'sd2147483647) begin
      de0_n = 32'h7fff_ffff;
    end else if (total < -37'sd2147483648) begin
      de0_n = 32'h8000_0000;
    end else begin
      de0_n = total[31:0];
    end
  end

  logic        s8_v;
  logic [31:0] s8_de0, s8_prev;
  logic [30:0] s8_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      s8_v <= 1'b0;
    end else if (en) begin
      s8_v <= h2_v;
    end
    if (en) begin
      s8_de0   <= de0_n;
      s8_prev  <= h2_prev;
      s8_scale <= h2_scale;
    end
  end

  // scaled distance and running minimum
  hpd_div #(.FB(FRAC_BITS)) u_div (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .in_valid     (s8_v),
    .de0_in       (s8_de0),
    .prev_in      (s8_prev),
    .scale_in     (s8_scale),
    .out_valid    (div_valid),
    .de0_out      (de0),
    .new_dist_out (new_dist)
  );

endmodule

@@ bench/hex_prism_distance_eval_test.sv @@
// testbench for hex_prism_distance_eval: directed table plus random points,
// checked against a behavioral predictor, or typed values for known rows.
// depends on hpd_pkg and the hex_prism_distance_eval rtl.
`timescale 1ns / 1ps

module hex_prism_distance_eval_test;
  import hpd_pkg::*;

  localparam int FB = 16;
  localparam int LATENCY = 65;
  localparam longint CYCLE_LIMIT = 2000000;
  localparam int N_RANDOM = 1030;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [31:0] pos_x = '0, pos_y = '0, pos_z = '0, prev_dist = '0;
  logic [30:0] de_scale = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [31:0] de0, new_dist;
  logic cfg_wen = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [CFG_DW-1:0] cfg_wdata = '0;

  hex_prism_distance_eval u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .prev_dist(prev_dist), .de_scale(de_scale),
    .out_valid(out_valid), .out_stall(out_stall),
    .de0(de0), .new_dist(new_dist),
    .cfg_wen(cfg_wen), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  typedef struct packed {
    logic [31:0] de0;
    logic [31:0] new_dist;
  } prism_result_t;

  typedef struct {
    logic [31:0] px, py, pz, prev;
    logic [30:0] scale;
    bit          known;
    prism_result_t res;
  } point_row_t;

  // shadow of the configuration registers
  longint radius_q, height_q, shell_q;
  bit     xy_swap, xz_swap, shell_on;

  prism_result_t pending_results[$];
  int  fail_count = 0;
  bit  hold_off = 1'b0;
  longint cycle_count = 0;

  // exact floor square root of a*a + b*b, operands below 2^36
  function automatic longint hyp_floor(longint a, longint b);
    logic [127:0] n, cand_sq;
    logic [63:0]  res, cand;
    n = 128'(a) * 128'(a) + 128'(b) * 128'(b);
    res = '0;
    for (int i = 40; i >= 0; i--) begin
      cand = res | (64'd1 << i);
      cand_sq = 128'(cand) * 128'(cand);
      if (cand_sq <= n) res = cand;
    end
    return longint'(res);
  endfunction

  // round to nearest by 2^30, ties toward plus infinity
  function automatic longint round_q30(logic signed [127:0] v);
    logic signed [127:0] w;
    w = v + (128'sd1 <<< 29);
    return longint'(w >>> 30);
  endfunction

  function automatic longint abs64(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic prism_result_t prism_distance(logic [31:0] ix, logic [31:0] iy,
      logic [31:0] iz, logic [31:0] iprev, logic [30:0] iscale);
    longint ax, ay, az, tmp, m, px, py, c, cx, sy, sd, hz, mx, my, lo, total, d, q;
    longint side, num, den;
    logic signed [127:0] t;
    prism_result_t r;
    ax = abs64(longint'($signed(ix)));
    ay = abs64(longint'($signed(iy)));
    az = abs64(longint'($signed(iz)));
    if (xy_swap) begin tmp = ax; ax = ay; ay = tmp; end
    if (xz_swap) begin tmp = ax; ax = az; az = tmp; end
    // fold across the hexagon edge normal
    t = 128'(ay) * 128'(longint'(K_HALF)) - 128'(ax) * 128'(longint'(K_SQRT_3_4));
    m = (t < 0) ? round_q30(t) : 0;
    px = ax + round_q30(128'(2 * m) * 128'(longint'(K_SQRT_3_4)));
    py = ay - m;
    // side distance, clamped along the edge
    c = round_q30(128'(longint'(K_SQRT_1_3)) * 128'(radius_q));
    cx = px < -c ? -c : (px > c ? c : px);
    sy = py - radius_q;
    side = hyp_floor(abs64(px - cx), abs64(sy));
    sd = sy > 0 ? side : (sy < 0 ? -side : 0);
    hz = az - height_q;
    if (shell_on) sd = abs64(sd) - shell_q;
    mx = sd > 0 ? sd : 0;
    my = hz > 0 ? hz : 0;
    lo = sd > hz ? sd : hz;
    if (lo > 0) lo = 0;
    total = lo + hyp_floor(mx, my);
    d = total > 64'sd2147483647 ? 64'sd2147483647 :
        (total < -64'sd2147483648 ? -64'sd2147483648 : total);
    num = abs64(d) << FB;
    den = longint'(iscale) + (64'sd1 << FB);
    q = num / den;
    if (d < 0) q = -q;
    if (longint'($signed(iprev)) < q) q = longint'($signed(iprev));
    r.de0 = d[31:0];
    r.new_dist = q[31:0];
    return r;
  endfunction

  task automatic write_reg(cfg_reg_t idx, longint value);
    @(negedge clk);
    cfg_wen <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= value[CFG_DW-1:0];
    @(negedge clk);
    cfg_wen <= 1'b0;
    case (idx)
      REG_HEX_RADIUS:      radius_q = value & 64'h7fffffff;
      REG_HALF_HEIGHT:     height_q = value & 64'h7fffffff;
      REG_SWAP_XY:         xy_swap = value[0];
      REG_SWAP_XZ:         xz_swap = value[0];
      REG_SHELL_ENABLE:    shell_on = value[0];
      REG_SHELL_THICKNESS: shell_q = value & 64'h7fffffff;
      default: ;
    endcase
  endtask

  task automatic write_setting(longint rad, longint hh, bit sxy, bit sxz, bit sh,
      longint th);
    write_reg(REG_HEX_RADIUS, rad);
    write_reg(REG_HALF_HEIGHT, hh);
    write_reg(REG_SWAP_XY, sxy);
    write_reg(REG_SWAP_XZ, sxz);
    write_reg(REG_SHELL_ENABLE, sh);
    write_reg(REG_SHELL_THICKNESS, th);
  endtask

  // wait until every expected item has come out, then let the pipe settle
  task automatic drain_pipe();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);
  endtask

  // offer one point and hold it until accepted; with gaps set, sometimes a gap afterwards
  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
      logic [31:0] p, logic [30:0] s, bit known, prism_result_t typed, bit gaps);
    prism_result_t exp_res;
    exp_res = prism_distance(x, y, z, p, s);
    if (known && exp_res != typed)
      $display("%0t note: table row differs from predictor for x=%h", $time, x);
    pending_results.push_back(known ? typed : exp_res);
    in_valid <= 1'b1;
    pos_x <= x; pos_y <= y; pos_z <= z; prev_dist <= p; de_scale <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    if (gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 9) == 0 ? $urandom_range(5, 30) : $urandom_range(1, 2))
        @(negedge clk);
    end
  endtask

  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 6 << FB)) - (3 << FB));
      2: return {{8{$urandom_range(0, 1) == 1}}, 24'($urandom())};
      default: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
    endcase
  endfunction

  // receiver: random stall with gaps, plus one long hold-off
  always @(negedge clk) begin
    if (rst) out_stall <= 1'b0;
    else if (hold_off) out_stall <= 1'b1;
    else if ($urandom_range(0, 1)) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 9) < 3);
  end

  // result checker
  always @(posedge clk) begin
    prism_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected item de0=%h new_dist=%h", $time, de0, new_dist);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (de0 !== want.de0) begin
          $display("%0t de0 mismatch expected %h actual %h", $time, want.de0, de0);
          fail_count++;
        end
        if (new_dist !== want.new_dist) begin
          $display("%0t new_dist mismatch expected %h actual %h", $time,
                   want.new_dist, new_dist);
          fail_count++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // hold-off process: stalls the output for a long stretch once
  initial begin
    wait (!rst);
    repeat (400) @(negedge clk);
    hold_off = 1'b1;
    repeat (300) @(negedge clk);
    hold_off = 1'b0;
  end

  point_row_t dir_rows[$];
  prism_result_t zr;

  initial begin
    int mode;
    radius_q = 65536; height_q = 65536; shell_q = 0;
    xy_swap = 0; xz_swap = 0; shell_on = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table: origin after reset reads off as -1.0, then the most
    // negative prev wins the minimum
    zr.de0 = 32'hffff0000; zr.new_dist = 32'hffff0000;
    dir_rows.push_back('{32'h0, 32'h0, 32'h0, 32'h7fffffff, 31'h0, 1, zr});
    zr.new_dist = 32'h80000000;
    dir_rows.push_back('{32'h0, 32'h0, 32'h0, 32'h80000000, 31'h0, 1, zr});
    dir_rows.push_back('{32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff,
                         31'h7fffffff, 0, zr});
    dir_rows.push_back('{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                         31'h0, 0, zr});
    dir_rows.push_back('{32'h0, 32'h00010000, 32'h0, 32'h7fffffff, 31'h0, 0, zr});
    dir_rows.push_back('{32'h0, 32'hffff0000, 32'h00010000, 32'h7fffffff, 31'h1, 0, zr});
    dir_rows.push_back('{32'h00020000, 32'h00008000, 32'hfffe0000, 32'h0,
                         31'h00010000, 0, zr});
    dir_rows.push_back('{32'hffff8000, 32'h00030000, 32'h00008000, 32'h7fffffff,
                         31'h7fffffff, 0, zr});
    dir_rows.push_back('{32'h00000001, 32'hffffffff, 32'h0, 32'hffffffff, 31'h0, 0, zr});
    foreach (dir_rows[i])
      send_point(dir_rows[i].px, dir_rows[i].py, dir_rows[i].pz, dir_rows[i].prev,
                 dir_rows[i].scale, dir_rows[i].known, dir_rows[i].res, 0);
    in_valid <= 1'b0;
    drain_pipe();

    // extreme and mixed settings, directed points again under the first three
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: write_setting(0, 0, 1, 1, 1, 0);
        1: write_setting(64'h7fffffff, 64'h7fffffff, 0, 1, 1, 64'h7fffffff);
        2: write_setting(3 << 15, 1 << 17, 1, 0, 1, 1 << 13);
        3: write_setting(1 << 16, 1 << 16, 0, 0, 0, 0);
        4: write_setting($urandom_range(0, 4 << 16), $urandom_range(0, 4 << 16),
                         $urandom_range(0, 1), $urandom_range(0, 1), 1,
                         $urandom_range(0, 1 << 16));
        default: write_setting($urandom() >> 1, $urandom() >> 1, $urandom_range(0, 1),
                               $urandom_range(0, 1), $urandom_range(0, 1),
                               $urandom() >> 1);
      endcase
      if (phase < 3)
        foreach (dir_rows[i])
          send_point(dir_rows[i].px, dir_rows[i].py, dir_rows[i].pz, dir_rows[i].prev,
                     dir_rows[i].scale, 0, zr, 0);
      // random points, mostly near the prism, a few huge or extreme
      for (int n = 0; n < N_RANDOM / 6; n++) begin
        mode = $urandom_range(0, 9) < 6 ? 1 : $urandom_range(0, 3);
        send_point(rand_coord(mode), rand_coord(mode), rand_coord(mode),
                   $urandom_range(0, 3) == 0 ? $urandom() : 32'h7fffffff,
                   $urandom_range(0, 1) ? 31'($urandom_range(0, 4 << 16))
                                        : 31'($urandom()),
                   0, zr, 1);
      end
      in_valid <= 1'b0;
      drain_pipe();
    end

    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/hpd_pkg.sv
design/hpd_hyp.sv
design/hpd_div.sv
design/hex_prism_distance_eval.sv
bench/hex_prism_distance_eval_test.sv
